### hw/rtl/windows1252_utf8_transcoder_top_assert.svh
// Assertion macros for the Windows-1252 / UTF-8 transcoder.
// Included by windows1252_utf8_transcoder_top.sv; no other dependencies.
`ifndef WINDOWS1252_UTF8_TRANSCODER_TOP_ASSERT_SVH
`define WINDOWS1252_UTF8_TRANSCODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define W12_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// next-cycle implication
`define W12_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define W12_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define W12_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/w1252u8_pkg.sv
// Shared types and constants for the Windows-1252 / UTF-8 transcoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package w1252u8_pkg;

  localparam logic OP_TO_UTF8   = 1'b0;
  localparam logic OP_TO_CP1252 = 1'b1;

  localparam logic [7:0]  ASCII_LIMIT     = 8'h80;
  localparam logic [7:0]  C1_LAST         = 8'h9F;
  localparam logic [7:0]  LATIN1_HI_SPLIT = 8'hBF;
  localparam logic [7:0]  LEAD2_BASE      = 8'hC2;
  localparam logic [7:0]  LEAD2_ENC       = 8'hC0;
  localparam logic [7:0]  LEAD3_ENC       = 8'hE0;
  localparam logic [7:0]  CONT_MASK       = 8'h3F;
  localparam logic [7:0]  CONT_BASE       = 8'h80;
  localparam logic [7:0]  UNMAPPED_BYTE   = 8'h81;
  localparam logic [15:0] CP_UNDEF        = 16'h0000;
  localparam logic [15:0] REPLACEMENT_CP  = 16'hFFFD;
  localparam logic [15:0] TWO_BYTE_LIMIT  = 16'h0800;
  localparam logic [20:0] CP_ASCII_LIMIT  = 21'h000080;
  localparam logic [20:0] LATIN1_MAX      = 21'h0000FF;

  // Code points for bytes 0x80..0x9F; CP_UNDEF marks an unassigned slot
  localparam logic [15:0] CP1252_HIGH [0:31] = '{
    16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
    16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
  };

  typedef struct packed {
    logic        op;
    logic [7:0]  byte_in;
    logic [20:0] code_point;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last;
  } out_item_t;

  // One classified item: up to three bytes, sent from index 0 to last_idx
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [2:0][7:0] bytes;
  } q_entry_t;

  typedef struct packed {
    logic     vld;
    q_entry_t ent;
  } q_push_t;

  typedef struct packed {
    logic     vld;
    q_entry_t ent;
  } q_head_t;

endpackage

`default_nettype wire

### hw/rtl/w1252u8_front.sv
// Front end: accepts items, classifies them and builds the byte sequence.
// Depends on w1252u8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module w1252u8_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  w1252u8_pkg::in_item_t in_data,
  input  wire                  q_full,
  output w1252u8_pkg::q_push_t q_push
);

  logic                  ent_valid_r, ent_valid_nxt;
  w1252u8_pkg::q_entry_t ent_r, ent_nxt;
  logic                  accept;

  logic [15:0] cp_fwd;
  logic        rev_hit;
  logic [4:0]  rev_idx;
  logic [7:0]  rev_byte;
  logic [7:0]  b;
  logic [20:0] cp;

  assign in_stall = ent_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  // reverse lookup: compare against all 32 slots at once
  always_comb begin
    cp      = in_data.code_point;
    rev_hit = 1'b0;
    rev_idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (w1252u8_pkg::CP1252_HIGH[i] != w1252u8_pkg::CP_UNDEF &&
          {5'b0, w1252u8_pkg::CP1252_HIGH[i]} == cp) begin
        rev_hit = 1'b1;
        rev_idx = 5'(i);
      end
    end
    priority if (cp < w1252u8_pkg::CP_ASCII_LIMIT) begin
      rev_byte = cp[7:0];
    end else if (rev_hit) begin
      rev_byte = {3'b100, rev_idx};
    end else if (cp > w1252u8_pkg::LATIN1_MAX) begin
      rev_byte = w1252u8_pkg::UNMAPPED_BYTE;
    end else begin
      rev_byte = cp[7:0];
    end
  end

  always_comb begin
    b       = in_data.byte_in;
    cp_fwd  = w1252u8_pkg::CP1252_HIGH[b[4:0]];
    ent_nxt = '0;
    if (cp_fwd == w1252u8_pkg::CP_UNDEF) begin
      cp_fwd = w1252u8_pkg::REPLACEMENT_CP;
    end
    if (in_data.op == w1252u8_pkg::OP_TO_CP1252) begin
      ent_nxt.bytes[0] = rev_byte;
    end else if (b < w1252u8_pkg::ASCII_LIMIT) begin
      ent_nxt.bytes[0] = b;
    end else if (b > w1252u8_pkg::C1_LAST) begin
      // Latin-1: C2/C3 lead, low six bits as continuation
      ent_nxt.bytes[0] = w1252u8_pkg::LEAD2_BASE +
                         {7'b0, b > w1252u8_pkg::LATIN1_HI_SPLIT};
      ent_nxt.bytes[1] = (b & w1252u8_pkg::CONT_MASK) + w1252u8_pkg::CONT_BASE;
      ent_nxt.last_idx = 2'd1;
    end else if (cp_fwd < w1252u8_pkg::TWO_BYTE_LIMIT) begin
      ent_nxt.bytes[0] = w1252u8_pkg::LEAD2_ENC | {3'b0, cp_fwd[10:6]};
      ent_nxt.bytes[1] = w1252u8_pkg::CONT_BASE | {2'b0, cp_fwd[5:0]};
      ent_nxt.last_idx = 2'd1;
    end else begin
      ent_nxt.bytes[0] = w1252u8_pkg::LEAD3_ENC | {4'b0, cp_fwd[15:12]};
      ent_nxt.bytes[1] = w1252u8_pkg::CONT_BASE | {2'b0, cp_fwd[11:6]};
      ent_nxt.bytes[2] = w1252u8_pkg::CONT_BASE | {2'b0, cp_fwd[5:0]};
      ent_nxt.last_idx = 2'd2;
    end
  end

  always_comb begin
    if (accept) begin
      ent_valid_nxt = 1'b1;
    end else if (ent_valid_r && !q_full) begin
      ent_valid_nxt = 1'b0;
    end else begin
      ent_valid_nxt = ent_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else begin
      ent_valid_r <= ent_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r <= ent_nxt;
    end
  end

  assign q_push.vld = ent_valid_r;
  assign q_push.ent = ent_r;

endmodule

`default_nettype wire

### hw/rtl/w1252u8_fifo.sv
// Short queue of classified items between front and back end.
// Depends on w1252u8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module w1252u8_fifo #(
  parameter int DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  w1252u8_pkg::q_push_t q_push,
  output logic                 q_full,
  output w1252u8_pkg::q_head_t q_head,
  input  wire                  q_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  w1252u8_pkg::q_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_full  = (count_r == CW'(DEPTH));
  assign do_push = q_push.vld && !q_full;
  assign do_pop  = q_pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_push.ent;
    end
  end

  assign q_head.vld = (count_r != '0);
  assign q_head.ent = mem[rd_ptr_r];

endmodule

`default_nettype wire

### hw/rtl/w1252u8_back.sv
// Back end: queued bytes leave via the output register, one per cycle unless stalled.
// Depends on w1252u8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module w1252u8_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  w1252u8_pkg::q_head_t   q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire                    out_stall,
  output w1252u8_pkg::out_item_t out_data
);

  logic                   cur_valid_r, cur_valid_nxt;
  w1252u8_pkg::q_entry_t  cur_r;
  logic [1:0]             idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  w1252u8_pkg::out_item_t out_r;
  logic                   load_out, cur_last;

  assign load_out = cur_valid_r && (!out_valid_r || !out_stall);
  assign cur_last = (idx_r == cur_r.last_idx);
  assign q_pop    = q_head.vld && (!cur_valid_r || (load_out && cur_last));

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 1'b1;
      if (cur_last) begin
        cur_valid_nxt = 1'b0;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head.ent;
    end
    if (load_out) begin
      out_r.byte_out <= cur_r.bytes[idx_r];
      out_r.last     <= cur_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### hw/rtl/windows1252_utf8_transcoder_top.sv
// Top level of the Windows-1252 / UTF-8 transcoder: front end, queue, back end.
// Depends on w1252u8_pkg, w1252u8_front, w1252u8_fifo, w1252u8_back and
// windows1252_utf8_transcoder_top_assert.svh.
//
//   channel  | ports                          | payload
//   ---------+--------------------------------+------------------------------
//   input    | in_valid, in_stall, in_data    | op, byte_in, code_point
//   result   | out_valid, out_stall, out_data | byte_out, last
//
// Each item yields one to three result bytes; the back end sends one byte per
// cycle while out_stall is low, and the input is taken every cycle while the
// queue has room.
// From acceptance to first byte an item passes the front register, the queue,
// the current-item register and the output register.
// Synchronous active-low reset empties the front register, queue and output.
// Output stall holds the output register; the queue absorbs QDEPTH items
// before the front register fills and in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

`include "windows1252_utf8_transcoder_top_assert.svh"

module windows1252_utf8_transcoder_top #(
  parameter int QDEPTH = 4
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  w1252u8_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output w1252u8_pkg::out_item_t out_data
);

  w1252u8_pkg::q_push_t q_push;
  w1252u8_pkg::q_head_t q_head;
  logic                 q_full;
  logic                 q_pop;

  // front end: classify and expand into a byte sequence
  w1252u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  // decoupling queue
  w1252u8_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // back end: one byte per cycle to the result channel while out_stall is low
  w1252u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // no entry carries more than three bytes
  `W12_ASSERT_IMP(a_entry_len, clk, rst_n, q_head.vld, q_head.ent.last_idx != 2'd3)
  // input only stalls when the queue is full
  `W12_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, q_full)
  // a full queue always presents a head entry
  `W12_ASSERT_IMP(a_full_head, clk, rst_n, q_full, q_head.vld)
  // head entry persists until the back end pops it
  `W12_ASSERT_NEXT(a_head_hold, clk, rst_n, q_head.vld && !q_pop, q_head.vld)

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for windows1252_utf8_transcoder_top: directed edge items, then random
// traffic in both directions. A scoreboard class predicts each result byte.
// Depends on w1252u8_pkg and the transcoder RTL.
module testbench;

  // Code points behind bytes 0x80..0x9F; zero marks an unassigned slot.
  // Slots 0x91..0x94 carry the published curly quotes.
  localparam logic [15:0] C1_CODE_POINT [0:31] = '{
    16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
    16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
  };

  // Byte-direction edges: ASCII ends, euro, an unassigned slot, a two-byte table entry,
  // the quote slots, the C1 end, and the Latin-1 lead-byte split.
  localparam logic [7:0] EDGE_BYTES [0:11] = '{
    8'h00, 8'h7F, 8'h80, 8'h81, 8'h83, 8'h91, 8'h94, 8'h9F, 8'hA0, 8'hBF, 8'hC0, 8'hFF
  };

  // Code-point edges: ASCII ends, table hits (incl. the quote fix), C1 passthrough,
  // Latin-1 end, first unmapped, the replacement char, beyond Unicode, field max.
  localparam logic [20:0] EDGE_CODES [0:11] = '{
    21'h000000, 21'h00007F, 21'h0020AC, 21'h002018, 21'h00201D, 21'h000178,
    21'h000080, 21'h0000FF, 21'h000100, 21'h00FFFD, 21'h110000, 21'h1FFFFF
  };

  // Expected result bytes, oldest first; one item adds one to three entries.
  class transcode_scoreboard;
    w1252u8_pkg::out_item_t expected_bytes[$];
    int errors;

    function void push_byte(logic [7:0] value, logic fin);
      w1252u8_pkg::out_item_t r;
      r.byte_out = value;
      r.last = fin;
      expected_bytes = {expected_bytes, r};
    endfunction

    function void note_input(w1252u8_pkg::in_item_t it);
      logic [7:0]  b;
      logic [15:0] cp;
      logic [7:0]  win;
      logic        hit;
      int          i;
      b = it.byte_in;
      if (it.op == w1252u8_pkg::OP_TO_CP1252) begin
        if (it.code_point < 21'h80) begin
          win = it.code_point[7:0];
        end else begin
          // reverse lookup first; fall back to passthrough or the unmapped byte
          hit = 1'b0;
          win = (it.code_point > 21'hFF) ? w1252u8_pkg::UNMAPPED_BYTE : it.code_point[7:0];
          for (i = 0; i < 32; i++) begin
            if (!hit && C1_CODE_POINT[i] != 16'h0000 &&
                {5'd0, C1_CODE_POINT[i]} == it.code_point) begin
              win = 8'h80 + 8'(i);
              hit = 1'b1;
            end
          end
        end
        push_byte(win, 1'b1);
      end else if (b < 8'h80) begin
        push_byte(b, 1'b1);
      end else if (b > 8'h9F) begin
        // Latin-1: lead is C2 or C3, trail keeps the low six bits
        push_byte(8'hC2 + ((b > 8'hBF) ? 8'h01 : 8'h00), 1'b0);
        push_byte({2'b10, b[5:0]}, 1'b1);
      end else begin
        cp = C1_CODE_POINT[b[4:0]];
        if (cp == 16'h0000) cp = 16'hFFFD;
        // every table entry is >= 0x80, so two or three bytes
        if (cp < 16'h0800) begin
          push_byte({3'b110, cp[10:6]}, 1'b0);
          push_byte({2'b10, cp[5:0]}, 1'b1);
        end else begin
          push_byte({4'b1110, cp[15:12]}, 1'b0);
          push_byte({2'b10, cp[11:6]}, 1'b0);
          push_byte({2'b10, cp[5:0]}, 1'b1);
        end
      end
    endfunction

    function void check_result(w1252u8_pkg::out_item_t got);
      w1252u8_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: byte_out=%02h last=%0b", got.byte_out, got.last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.byte_out !== want.byte_out) begin
        $error("byte_out: expected %02h, got %02h", want.byte_out, got.byte_out);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  w1252u8_pkg::in_item_t  in_data;
  logic                   out_valid;
  logic                   out_stall;
  w1252u8_pkg::out_item_t out_data;

  transcode_scoreboard sb;
  bit no_idle;  // when set, neither side inserts gaps or stalls

  windows1252_utf8_transcoder_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap or stall length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Random item; unused field is random too so all its bits toggle.
  function automatic w1252u8_pkg::in_item_t random_item();
    w1252u8_pkg::in_item_t it;
    int pick;
    int idx;
    it.op = ($urandom_range(0, 1) != 0) ? w1252u8_pkg::OP_TO_CP1252 : w1252u8_pkg::OP_TO_UTF8;
    it.byte_in = 8'($urandom);
    it.code_point = 21'($urandom);
    pick = $urandom_range(0, 99);
    if (it.op == w1252u8_pkg::OP_TO_UTF8) begin
      // lean on the table range, it has the most cases
      if (pick < 35) it.byte_in = 8'h80 + 8'($urandom_range(0, 31));
    end else if (pick < 40) begin
      do idx = $urandom_range(0, 31); while (C1_CODE_POINT[idx] == 16'h0000);
      it.code_point = {5'd0, C1_CODE_POINT[idx]};
    end else if (pick < 60) begin
      it.code_point = 21'($urandom_range(0, 255));
    end else if (pick < 80) begin
      it.code_point = 21'($urandom_range(0, 16'hFFFF));
    end
    return it;
  endfunction

  // Present one item and hold it until accepted. Valid stays high across
  // back-to-back items; it only drops when a gap is drawn.
  task automatic send_item(input w1252u8_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result side back-pressure: random stall bursts separated by open windows.
  initial begin : result_stall
    int len;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      len = pick_gap();
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Both handshakes sampled at the edge, i.e. pre-edge values of everything.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  initial begin : stimulus
    w1252u8_pkg::in_item_t it;
    int i;
    int n;
    sb = new();
    no_idle = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte direction edges
    for (i = 0; i < 12; i++) begin
      it = random_item();
      it.op = w1252u8_pkg::OP_TO_UTF8;
      it.byte_in = EDGE_BYTES[i];
      send_item(it);
    end
    // directed: code-point direction edges
    for (i = 0; i < 12; i++) begin
      it = random_item();
      it.op = w1252u8_pkg::OP_TO_CP1252;
      it.code_point = EDGE_CODES[i];
      send_item(it);
    end

    // random traffic; every third block of 40 runs with no gaps or stalls
    for (n = 0; n < 236; n++) begin
      no_idle = ((n / 40) % 3 == 2);
      send_item(random_item());
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;
    // let the monitor note the last accepted item before testing for drain
    @(posedge clk);

    // drain, then wait on to catch stray output past the pipeline depth
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

### windows1252_utf8_transcoder_top.f
+incdir+hw/rtl
hw/rtl/w1252u8_pkg.sv
hw/rtl/w1252u8_front.sv
hw/rtl/w1252u8_fifo.sv
hw/rtl/w1252u8_back.sv
hw/rtl/windows1252_utf8_transcoder_top.sv
tb/sv/testbench.sv
